[sv/lcfc_pkg.sv]
// Shared types, constants and the CRC byte step for the link control frame checker.
`timescale 1ns / 1ps

package lcfc_pkg;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

  // Fixed magics
  localparam logic [31:0] MAGIC_DECISION  = 32'h444C4B31;
  localparam logic [31:0] MAGIC_HELLO     = 32'h444C4845;
  localparam logic [31:0] MAGIC_HELLO_ACK = 32'h444C4841;

  // Payload sizes per kind
  localparam logic [5:0] PSIZE_PING    = 6'd20;
  localparam logic [5:0] PSIZE_PONG    = 6'd36;
  localparam logic [5:0] PSIZE_DEFAULT = 6'd28;

  localparam logic [5:0] INDEX_LIMIT = 6'd63;

  // Configuration register indexes
  localparam logic [1:0] CFG_PING_MAGIC       = 2'd0;
  localparam logic [1:0] CFG_PONG_MAGIC       = 2'd1;
  localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd2;

  typedef enum logic [2:0] {
    KIND_UNKNOWN   = 3'd0,
    KIND_DECISION  = 3'd1,
    KIND_PING      = 3'd2,
    KIND_PONG      = 3'd3,
    KIND_HELLO     = 3'd4,
    KIND_HELLO_ACK = 3'd5
  } lcfc_kind_e;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_SHORT       = 3'd1,
    STATUS_BAD_MAGIC   = 3'd2,
    STATUS_BAD_VERSION = 3'd3,
    STATUS_BAD_CRC     = 3'd4
  } lcfc_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } lcfc_in_t;

  typedef struct packed {
    logic [2:0]  frame_kind;
    logic [2:0]  frame_status;
    logic [7:0]  frame_flags;
    logic [31:0] word_at_eight;
    logic [63:0] word_at_twelve;
  } lcfc_out_t;

  // Advance the CRC by one byte, eight bit steps unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

[sv/link_control_frame_checker_unit.sv]
// Top level of the link control frame checker: byte capture, CRC and frame verdict.
`timescale 1ns / 1ps

//  channel  | signals                              | beat
//  ---------+--------------------------------------+------------------------------
//  in       | in_valid_i, in_ready_o, in_data_i    | one frame byte, last mark
//  out      | out_valid_o, out_ready_i, out_data_o | one verdict per frame
//  cfg      | cfg_we_i, cfg_index_i, cfg_data_i    | one register write
//
// One byte a cycle while the result register is not stalled; a byte is held in the
// input register, where the CRC step and field capture are done, and the verdict
// for a frame's last byte lands in the result register.
// Reset clears frame state and configuration to their defaults at once.
// A stalled result holds the input register; a new byte is still taken whenever
// the input register moves on.

module link_control_frame_checker_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lcfc_pkg::lcfc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lcfc_pkg::lcfc_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import lcfc_pkg::*;

  // Configuration
  logic [31:0] ping_magic_q, pong_magic_q;
  logic [7:0]  exp_version_q;

  // Input register
  logic     s1_valid_q;
  lcfc_in_t s1_data_q;
  logic     advance;

  // Frame state
  logic [5:0]  byte_index_q, byte_index_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] magic_q, magic_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] word8_q, word8_d;
  logic [63:0] word12_q, word12_d;
  logic [31:0] trailer_q, trailer_d;
  logic [31:0] crc_end_q, crc_end_d;

  // Result register
  logic      out_valid_q;
  lcfc_out_t out_data_q, out_data_d;

  // Step signals
  logic [5:0]   pos;
  logic [7:0]   b;
  lcfc_kind_e   kind;
  lcfc_status_e status;
  logic [5:0]   psize;
  logic [5:0]   psize_end;
  logic [1:0]   tr_lane;
  logic [2:0]   w12_lane;
  logic [1:0]   w8_lane;
  logic [1:0]   mg_lane;

  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_magic_q  <= '0;
      pong_magic_q  <= '0;
      exp_version_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PING_MAGIC:       ping_magic_q  <= cfg_data_i;
        CFG_PONG_MAGIC:       pong_magic_q  <= cfg_data_i;
        CFG_EXPECTED_VERSION: exp_version_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Hold the input beat until the result side can move
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // Capture fields, advance CRC and decide the verdict for the held byte
  always_comb begin
    pos      = byte_index_q;
    b        = s1_data_q.data_byte;
    mg_lane  = 2'd3 - pos[1:0];
    w8_lane  = 2'd3 - pos[1:0];
    w12_lane = 3'd3 - pos[2:0];

    magic_d   = magic_q;
    version_d = version_q;
    flags_d   = flags_q;
    word8_d   = word8_q;
    word12_d  = word12_q;

    if (pos < 6'd4) begin
      magic_d = magic_q | ({24'd0, b} << {mg_lane, 3'b000});
    end else if (pos == 6'd4) begin
      version_d = b;
    end else if (pos == 6'd5) begin
      flags_d = b;
    end else if (pos >= 6'd8 && pos < 6'd12) begin
      word8_d = word8_q | ({24'd0, b} << {w8_lane, 3'b000});
    end
    if (pos >= 6'd12 && pos < 6'd20) begin
      word12_d = word12_q | ({56'd0, b} << {w12_lane, 3'b000});
    end

    crc_d = crc_byte(crc_q, b);

    // Kind from the magic as it stands after this byte
    if (pos < 6'd3)                      kind = KIND_UNKNOWN;
    else if (magic_d == MAGIC_DECISION)  kind = KIND_DECISION;
    else if (magic_d == ping_magic_q)    kind = KIND_PING;
    else if (magic_d == pong_magic_q)    kind = KIND_PONG;
    else if (magic_d == MAGIC_HELLO)     kind = KIND_HELLO;
    else if (magic_d == MAGIC_HELLO_ACK) kind = KIND_HELLO_ACK;
    else                                 kind = KIND_UNKNOWN;

    unique case (kind)
      KIND_PING: psize = PSIZE_PING;
      KIND_PONG: psize = PSIZE_PONG;
      default:   psize = PSIZE_DEFAULT;
    endcase
    psize_end = psize + 6'd3;
    tr_lane   = psize_end[1:0] - pos[1:0];

    crc_end_d = crc_end_q;
    trailer_d = trailer_q;
    if (kind != KIND_UNKNOWN) begin
      if (pos + 6'd1 == psize) begin
        crc_end_d = crc_d ^ CRC_ALL_ONES;
      end
      if (pos >= psize && pos <= psize_end) begin
        trailer_d = trailer_q | ({24'd0, b} << {tr_lane, 3'b000});
      end
    end

    byte_index_d = (pos < INDEX_LIMIT) ? pos + 6'd1 : pos;

    // Checks in priority order
    if (kind == KIND_UNKNOWN) begin
      status = (pos < 6'd3) ? STATUS_SHORT : STATUS_BAD_MAGIC;
    end else if (pos < psize_end) begin
      status = STATUS_SHORT;
    end else if (version_d != exp_version_q) begin
      status = STATUS_BAD_VERSION;
    end else if (trailer_d != crc_end_d) begin
      status = STATUS_BAD_CRC;
    end else begin
      status = STATUS_OK;
    end

    out_data_d.frame_kind     = kind;
    out_data_d.frame_status   = status;
    out_data_d.frame_flags    = flags_d;
    out_data_d.word_at_eight  = word8_d;
    out_data_d.word_at_twelve = word12_d;
  end

  // Update frame state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      crc_q        <= CRC_ALL_ONES;
      magic_q      <= '0;
      version_q    <= '0;
      flags_q      <= '0;
      word8_q      <= '0;
      word12_q     <= '0;
      trailer_q    <= '0;
      crc_end_q    <= '0;
    end else if (s1_valid_q && advance) begin
      if (s1_data_q.last_byte) begin
        byte_index_q <= '0;
        crc_q        <= CRC_ALL_ONES;
        magic_q      <= '0;
        version_q    <= '0;
        flags_q      <= '0;
        word8_q      <= '0;
        word12_q     <= '0;
        trailer_q    <= '0;
        crc_end_q    <= '0;
      end else begin
        byte_index_q <= byte_index_d;
        crc_q        <= crc_d;
        magic_q      <= magic_d;
        version_q    <= version_d;
        flags_q      <= flags_d;
        word8_q      <= word8_d;
        word12_q     <= word12_d;
        trailer_q    <= trailer_d;
        crc_end_q    <= crc_end_d;
      end
    end
  end

  // Load the result register on a last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && s1_data_q.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q && s1_data_q.last_byte) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

[sv/lcfc_checker.sv]
// Port-level checks for the link control frame checker, bound to the top level.
`timescale 1ns / 1ps

module lcfc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lcfc_pkg::lcfc_out_t out_data_o
);
  import lcfc_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Back-pressure only while a result is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // An unknown kind is reported only as short or bad magic
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_kind == KIND_UNKNOWN |->
      out_data_o.frame_status == STATUS_SHORT ||
      out_data_o.frame_status == STATUS_BAD_MAGIC)
    else $error("unknown kind with a kind-specific status");

  // Bad magic never comes with a known kind
  a_magic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.frame_status == STATUS_BAD_MAGIC) |->
      out_data_o.frame_kind == KIND_UNKNOWN)
    else $error("bad magic with a known kind");

endmodule

bind link_control_frame_checker_unit lcfc_checker u_lcfc_checker (.*);
